[sv/i2e_pkg.sv]
package i2e_pkg;

  localparam logic [7:0] BYTE_ESC    = 8'h1b;
  localparam logic [7:0] BYTE_SO     = 8'h0e;
  localparam logic [7:0] BYTE_SI     = 8'h0f;
  localparam logic [7:0] BYTE_HIGH   = 8'h80;
  localparam logic [7:0] JIS_LO      = 8'h21;
  localparam logic [7:0] JIS_HI      = 8'h7e;
  localparam logic [7:0] CHAR_PAREN  = 8'h28;
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_B      = 8'h42;
  localparam logic [7:0] CHAR_J      = 8'h4a;
  localparam logic [7:0] CHAR_AT     = 8'h40;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_ESC    = 3'd1,
    PH_PAREN  = 3'd2,
    PH_DOLLAR = 3'd3,
    PH_JIS2   = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_INVALID    = 2'd1,
    ERR_INCOMPLETE = 2'd2
  } err_t;

  typedef enum logic {
    MODE_ASCII = 1'b0,
    MODE_JIS   = 1'b1
  } mode_t;

  typedef struct packed {
    logic       two;
    logic [7:0] byte0;
    logic [7:0] byte1;
    err_t       err;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

[sv/i2e_ifs.sv]
interface i2e_iso_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] in_byte;

  modport source (output valid, output op, output in_byte, input ready);
  modport sink   (input valid, input op, input in_byte, output ready);
endinterface

interface i2e_euc_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] error_code;
  logic       last;

  modport source (output valid, output out_byte, output error_code, output last, input ready);
  modport sink   (input valid, input out_byte, input error_code, input last, output ready);
endinterface

[sv/i2e_front.sv]
module i2e_front (
  input  logic                clk,
  input  logic                rst,
  i2e_iso_if.sink             iso,
  input  i2e_pkg::q_status_t  stat,
  output logic                push,
  output i2e_pkg::cmd_t       cmd
);

  i2e_pkg::phase_t phase, phase_next;
  i2e_pkg::mode_t  mode, mode_next;
  logic [6:0]      held, held_next;
  logic            accept;
  logic            cmd_valid;
  logic [7:0]      b;
  logic            jis_byte;
  logic            bad_lead;

  assign b        = iso.in_byte;
  assign jis_byte = (b >= i2e_pkg::JIS_LO) && (b <= i2e_pkg::JIS_HI);
  assign bad_lead = (b == i2e_pkg::BYTE_SO) || (b == i2e_pkg::BYTE_SI) || b[7];
  assign iso.ready = !stat.full;
  assign accept    = iso.valid && iso.ready;
  assign push      = accept && cmd_valid;

  always_comb begin
    phase_next = i2e_pkg::PH_IDLE;
    mode_next  = mode;
    held_next  = held;
    if (!iso.op) begin
      unique case (phase)
        i2e_pkg::PH_ESC: begin
          if (b == i2e_pkg::CHAR_PAREN) phase_next = i2e_pkg::PH_PAREN;
          else if (b == i2e_pkg::CHAR_DOLLAR) phase_next = i2e_pkg::PH_DOLLAR;
        end
        i2e_pkg::PH_PAREN: begin
          if (b == i2e_pkg::CHAR_B || b == i2e_pkg::CHAR_J) mode_next = i2e_pkg::MODE_ASCII;
        end
        i2e_pkg::PH_DOLLAR: begin
          if (b == i2e_pkg::CHAR_AT || b == i2e_pkg::CHAR_B) mode_next = i2e_pkg::MODE_JIS;
        end
        i2e_pkg::PH_JIS2: begin
          phase_next = i2e_pkg::PH_IDLE;
        end
        default: begin
          if (b == i2e_pkg::BYTE_ESC) begin
            phase_next = i2e_pkg::PH_ESC;
          end else if (!bad_lead && mode == i2e_pkg::MODE_JIS && jis_byte) begin
            phase_next = i2e_pkg::PH_JIS2;
            held_next  = b[6:0];
          end
        end
      endcase
    end
  end

  always_comb begin
    cmd_valid = 1'b0;
    cmd.two   = 1'b0;
    cmd.byte0 = 8'h00;
    cmd.byte1 = b | i2e_pkg::BYTE_HIGH;
    cmd.err   = i2e_pkg::ERR_INVALID;
    if (iso.op) begin
      cmd_valid = (phase != i2e_pkg::PH_IDLE);
      cmd.err   = i2e_pkg::ERR_INCOMPLETE;
    end else begin
      unique case (phase)
        i2e_pkg::PH_ESC: begin
          cmd_valid = !(b == i2e_pkg::CHAR_PAREN || b == i2e_pkg::CHAR_DOLLAR);
        end
        i2e_pkg::PH_PAREN: begin
          cmd_valid = !(b == i2e_pkg::CHAR_B || b == i2e_pkg::CHAR_J);
        end
        i2e_pkg::PH_DOLLAR: begin
          cmd_valid = !(b == i2e_pkg::CHAR_AT || b == i2e_pkg::CHAR_B);
        end
        i2e_pkg::PH_JIS2: begin
          cmd_valid = 1'b1;
          if (jis_byte) begin
            cmd.two   = 1'b1;
            cmd.byte0 = {1'b1, held};
            cmd.err   = i2e_pkg::ERR_NONE;
          end
        end
        default: begin
          if (b == i2e_pkg::BYTE_ESC) begin
            cmd_valid = 1'b0;
          end else if (bad_lead) begin
            cmd_valid = 1'b1;
          end else if (mode == i2e_pkg::MODE_ASCII) begin
            cmd_valid = 1'b1;
            cmd.byte0 = b;
            cmd.err   = i2e_pkg::ERR_NONE;
          end else begin
            cmd_valid = !jis_byte;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= i2e_pkg::PH_IDLE;
      mode  <= i2e_pkg::MODE_ASCII;
      held  <= 7'h00;
    end else if (accept) begin
      phase <= phase_next;
      mode  <= mode_next;
      held  <= held_next;
    end
  end

  a_held_printable: assert property (@(posedge clk) disable iff (rst)
    phase == i2e_pkg::PH_JIS2 |-> (held >= 7'h21 && held <= 7'h7e))
    else $error("held JIS lead byte out of range");

  a_jis2_needs_mode: assert property (@(posedge clk) disable iff (rst)
    phase == i2e_pkg::PH_JIS2 |-> mode == i2e_pkg::MODE_JIS)
    else $error("JIS pair pending outside JIS mode");

endmodule

[sv/i2e_fifo.sv]
module i2e_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  i2e_pkg::cmd_t       wr_cmd,
  input  logic                pop,
  output i2e_pkg::cmd_t       rd_cmd,
  output i2e_pkg::q_status_t  stat
);

  i2e_pkg::cmd_t                 entries [i2e_pkg::FIFO_DEPTH];
  logic [i2e_pkg::FIFO_AW-1:0]   wr_ptr;
  logic [i2e_pkg::FIFO_AW-1:0]   rd_ptr;
  logic [i2e_pkg::FIFO_CW-1:0]   count;

  assign stat.empty = (count == '0);
  assign stat.full  = (count == i2e_pkg::FIFO_CW'(i2e_pkg::FIFO_DEPTH));
  assign rd_cmd     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !stat.full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !stat.empty)
    else $error("pop from empty queue");

endmodule

[sv/i2e_back.sv]
module i2e_back (
  input  logic                clk,
  input  logic                rst,
  input  i2e_pkg::cmd_t       head,
  input  i2e_pkg::q_status_t  stat,
  output logic                pop,
  i2e_euc_if.source           euc
);

  logic          valid;
  logic [7:0]    data;
  i2e_pkg::err_t err;
  logic          last_flag;
  logic          pending;
  logic [7:0]    spare;
  logic          load;

  assign load = !valid || euc.ready;
  assign pop  = load && !pending && !stat.empty;

  assign euc.valid      = valid;
  assign euc.out_byte   = data;
  assign euc.error_code = err;
  assign euc.last       = last_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      pending <= 1'b0;
    end else if (load) begin
      if (pending) begin
        valid   <= 1'b1;
        pending <= 1'b0;
      end else begin
        valid   <= !stat.empty;
        pending <= pop && head.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (pending) begin
        data      <= spare;
        err       <= i2e_pkg::ERR_NONE;
        last_flag <= 1'b1;
      end else begin
        data      <= head.byte0;
        err       <= head.err;
        last_flag <= !head.two;
        spare     <= head.byte1;
      end
    end
  end

  a_pending_needs_valid: assert property (@(posedge clk) disable iff (rst)
    pending |-> valid)
    else $error("second byte pending without a first");

  a_second_follows: assert property (@(posedge clk) disable iff (rst)
    pending && euc.ready |=> valid && last_flag && err == i2e_pkg::ERR_NONE)
    else $error("second byte of pair not issued");

  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    valid && err != i2e_pkg::ERR_NONE |-> last_flag)
    else $error("error result not marked last");

endmodule

[sv/iso2022jp_to_eucjp_decoder_core.sv]
// A result is registered twice, in a queue entry and then in the output register,
// before it is presented on the output.
// Throughput: one input byte per cycle while the queue is not full; one result
// per cycle while the sink is ready, so a JIS pair issues its two bytes in turn.
// A four-entry queue between the parser and the output stage absorbs output stalls.
// Reset (rst, synchronous): parser idle, ASCII mode, queue and output emptied.
module iso2022jp_to_eucjp_decoder_core (
  input  logic       clk,
  input  logic       rst,
  i2e_iso_if.sink    iso,
  i2e_euc_if.source  euc
);

  i2e_pkg::cmd_t      wr_cmd;
  i2e_pkg::cmd_t      rd_cmd;
  i2e_pkg::q_status_t stat;
  logic               push;
  logic               pop;

  i2e_front u_front (
    .clk  (clk),
    .rst  (rst),
    .iso  (iso),
    .stat (stat),
    .push (push),
    .cmd  (wr_cmd)
  );

  i2e_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_cmd (wr_cmd),
    .pop    (pop),
    .rd_cmd (rd_cmd),
    .stat   (stat)
  );

  i2e_back u_back (
    .clk  (clk),
    .rst  (rst),
    .head (rd_cmd),
    .stat (stat),
    .pop  (pop),
    .euc  (euc)
  );

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps

module testbench;

  localparam int ITEMS      = 950;
  localparam int CYCLE_MAX  = 400000;
  localparam int HOLD_SPAN  = 80;
  localparam int TAIL_WAIT  = 8;

  typedef struct packed {
    logic [7:0]    data;
    i2e_pkg::err_t err;
    logic          last;
  } euc_word_t;

  typedef struct {
    bit            op;
    logic [7:0]    b;
    bit            typed;
    int            n;
    logic [7:0]    exp_b;
    i2e_pkg::err_t exp_err;
  } iso_item_t;

  logic clk;
  logic rst;

  i2e_iso_if iso_ch ();
  i2e_euc_if euc_ch ();

  iso2022jp_to_eucjp_decoder_core dut (
    .clk (clk),
    .rst (rst),
    .iso (iso_ch),
    .euc (euc_ch)
  );

  i2e_pkg::phase_t ph_s   = i2e_pkg::PH_IDLE;
  i2e_pkg::mode_t  mode_s = i2e_pkg::MODE_ASCII;
  logic [6:0]      held_s = 7'd0;

  euc_word_t   euc_exp_q[$];
  iso_item_t   offered_q[$];
  iso_item_t   burst_q[$];
  iso_item_t   directed [0:24];

  int          mismatches = 0;
  int          accepted   = 0;
  int          cycles     = 0;
  bit          calm       = 1'b0;
  bit          hold_out   = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_MAX) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic void decode_byte(input bit op, input logic [7:0] b,
                                      output euc_word_t res [2], output int n);
    bit bad;
    bad    = 1'b0;
    n      = 0;
    res[0] = euc_word_t'{8'h00, i2e_pkg::ERR_NONE, 1'b1};
    res[1] = res[0];
    if (op) begin
      if (ph_s != i2e_pkg::PH_IDLE) begin
        n          = 1;
        res[0].err = i2e_pkg::ERR_INCOMPLETE;
      end
      ph_s = i2e_pkg::PH_IDLE;
    end else begin
      case (ph_s)
        i2e_pkg::PH_ESC: begin
          if (b == i2e_pkg::CHAR_PAREN) ph_s = i2e_pkg::PH_PAREN;
          else if (b == i2e_pkg::CHAR_DOLLAR) ph_s = i2e_pkg::PH_DOLLAR;
          else bad = 1'b1;
        end
        i2e_pkg::PH_PAREN: begin
          if (b == i2e_pkg::CHAR_B || b == i2e_pkg::CHAR_J) begin
            mode_s = i2e_pkg::MODE_ASCII;
            ph_s   = i2e_pkg::PH_IDLE;
          end else bad = 1'b1;
        end
        i2e_pkg::PH_DOLLAR: begin
          if (b == i2e_pkg::CHAR_AT || b == i2e_pkg::CHAR_B) begin
            mode_s = i2e_pkg::MODE_JIS;
            ph_s   = i2e_pkg::PH_IDLE;
          end else bad = 1'b1;
        end
        i2e_pkg::PH_JIS2: begin
          if (b >= i2e_pkg::JIS_LO && b <= i2e_pkg::JIS_HI) begin
            n      = 2;
            res[0] = euc_word_t'{{1'b1, held_s}, i2e_pkg::ERR_NONE, 1'b0};
            res[1] = euc_word_t'{b | i2e_pkg::BYTE_HIGH, i2e_pkg::ERR_NONE, 1'b1};
            ph_s   = i2e_pkg::PH_IDLE;
          end else bad = 1'b1;
        end
        default: begin
          if (b == i2e_pkg::BYTE_ESC) begin
            ph_s = i2e_pkg::PH_ESC;
          end else if (b == i2e_pkg::BYTE_SO || b == i2e_pkg::BYTE_SI ||
                       b >= i2e_pkg::BYTE_HIGH) begin
            bad = 1'b1;
          end else if (mode_s == i2e_pkg::MODE_ASCII) begin
            n           = 1;
            res[0].data = b;
          end else if (b >= i2e_pkg::JIS_LO && b <= i2e_pkg::JIS_HI) begin
            held_s = b[6:0];
            ph_s   = i2e_pkg::PH_JIS2;
          end else bad = 1'b1;
        end
      endcase
    end
    if (bad) begin
      n      = 1;
      res[0] = euc_word_t'{8'h00, i2e_pkg::ERR_INVALID, 1'b1};
      ph_s   = i2e_pkg::PH_IDLE;
    end
  endfunction

  always @(posedge clk) begin : monitor
    iso_item_t it;
    euc_word_t res [2];
    euc_word_t e;
    int        n;
    if (!rst) begin
      if (iso_ch.valid && iso_ch.ready) begin
        it = offered_q.pop_front();
        decode_byte(it.op, it.b, res, n);
        if (it.typed) begin
          if (it.n == 1) euc_exp_q.push_back(euc_word_t'{it.exp_b, it.exp_err, 1'b1});
        end else begin
          for (int k = 0; k < n; k++) euc_exp_q.push_back(res[k]);
        end
      end
      if (euc_ch.valid && euc_ch.ready) begin
        if (euc_exp_q.size() == 0) begin
          $error("unexpected result: out_byte %02h error_code %0d last %0b",
                 euc_ch.out_byte, euc_ch.error_code, euc_ch.last);
          mismatches++;
        end else begin
          e = euc_exp_q.pop_front();
          if (euc_ch.out_byte !== e.data) begin
            $error("out_byte: expected %02h, actual %02h", e.data, euc_ch.out_byte);
            mismatches++;
          end
          if (euc_ch.error_code !== e.err) begin
            $error("error_code: expected %0d, actual %0d", e.err, euc_ch.error_code);
            mismatches++;
          end
          if (euc_ch.last !== e.last) begin
            $error("last: expected %0b, actual %0b", e.last, euc_ch.last);
            mismatches++;
          end
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic iso_item_t mk(input bit op, input logic [7:0] b);
    return '{op, b, 1'b0, 0, 8'h00, i2e_pkg::ERR_NONE};
  endfunction

  function automatic logic [7:0] ascii_byte();
    logic [7:0] r;
    do r = 8'($urandom_range(0, 127));
    while (r == i2e_pkg::BYTE_SO || r == i2e_pkg::BYTE_SI || r == i2e_pkg::BYTE_ESC);
    return r;
  endfunction

  function automatic logic [7:0] jis_byte();
    return 8'($urandom_range(i2e_pkg::JIS_LO, i2e_pkg::JIS_HI));
  endfunction

  function automatic logic [7:0] non_jis_byte();
    if ($urandom_range(0, 1)) return 8'($urandom_range(0, 8'h20));
    return 8'($urandom_range(8'h7f, 8'hff));
  endfunction

  function automatic void fill_burst();
    int kind;
    int len;
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      if ($urandom_range(0, 2) == 0) begin
        burst_q.push_back(mk(0, i2e_pkg::BYTE_ESC));
        burst_q.push_back(mk(0, i2e_pkg::CHAR_PAREN));
        burst_q.push_back(mk(0, $urandom_range(0, 1) ? i2e_pkg::CHAR_B : i2e_pkg::CHAR_J));
      end
      len = $urandom_range(1, 12);
      repeat (len) burst_q.push_back(mk(0, ascii_byte()));
    end else if (kind < 60) begin
      burst_q.push_back(mk(0, i2e_pkg::BYTE_ESC));
      burst_q.push_back(mk(0, i2e_pkg::CHAR_DOLLAR));
      burst_q.push_back(mk(0, $urandom_range(0, 1) ? i2e_pkg::CHAR_AT : i2e_pkg::CHAR_B));
      len = $urandom_range(1, 6);
      repeat (len) begin
        burst_q.push_back(mk(0, jis_byte()));
        burst_q.push_back(mk(0, jis_byte()));
      end
      burst_q.push_back(mk(0, i2e_pkg::BYTE_ESC));
      burst_q.push_back(mk(0, i2e_pkg::CHAR_PAREN));
      burst_q.push_back(mk(0, $urandom_range(0, 1) ? i2e_pkg::CHAR_B : i2e_pkg::CHAR_J));
    end else if (kind < 70) begin
      burst_q.push_back(mk(0, i2e_pkg::BYTE_ESC));
      burst_q.push_back(mk(0, $urandom_range(0, 1) ? i2e_pkg::CHAR_PAREN
                                                   : i2e_pkg::CHAR_DOLLAR));
      burst_q.push_back(mk(0, 8'($urandom_range(0, 255))));
    end else if (kind < 75) begin
      burst_q.push_back(mk(0, i2e_pkg::BYTE_ESC));
      burst_q.push_back(mk(0, 8'($urandom_range(0, 255))));
    end else if (kind < 82) begin
      burst_q.push_back(mk(0, i2e_pkg::BYTE_ESC));
      burst_q.push_back(mk(0, i2e_pkg::CHAR_DOLLAR));
      burst_q.push_back(mk(0, i2e_pkg::CHAR_B));
      burst_q.push_back(mk(0, jis_byte()));
      burst_q.push_back(mk(0, non_jis_byte()));
    end else if (kind < 90) begin
      len = $urandom_range(1, 4);
      repeat (len) burst_q.push_back(mk(0, 8'($urandom_range(0, 255))));
    end else if (kind < 95) begin
      case ($urandom_range(0, 2))
        0: burst_q.push_back(mk(0, i2e_pkg::BYTE_ESC));
        1: begin
          burst_q.push_back(mk(0, i2e_pkg::BYTE_ESC));
          burst_q.push_back(mk(0, $urandom_range(0, 1) ? i2e_pkg::CHAR_PAREN
                                                       : i2e_pkg::CHAR_DOLLAR));
        end
        default: begin
          burst_q.push_back(mk(0, i2e_pkg::BYTE_ESC));
          burst_q.push_back(mk(0, i2e_pkg::CHAR_DOLLAR));
          burst_q.push_back(mk(0, i2e_pkg::CHAR_AT));
          burst_q.push_back(mk(0, jis_byte()));
        end
      endcase
      burst_q.push_back(mk(1, 8'($urandom_range(0, 255))));
    end else begin
      burst_q.push_back(mk(1, 8'($urandom_range(0, 255))));
    end
  endfunction

  task automatic offer(input iso_item_t it);
    int g;
    g = (calm || hold_out) ? 0 : pick_gap();
    repeat (g) begin
      @(negedge clk);
      iso_ch.valid <= 1'b0;
    end
    @(negedge clk);
    offered_q.push_back(it);
    iso_ch.valid   <= 1'b1;
    iso_ch.op      <= it.op;
    iso_ch.in_byte <= it.b;
    do @(posedge clk); while (!iso_ch.ready);
    accepted++;
  endtask

  task automatic drain();
    @(negedge clk);
    iso_ch.valid <= 1'b0;
    while (euc_exp_q.size() != 0) @(posedge clk);
  endtask

  // sink side: random stalls, always ready while calm, one long hold-off on request
  initial begin
    int g;
    euc_ch.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_out) begin
        repeat (HOLD_SPAN) begin
          @(negedge clk);
          euc_ch.ready <= 1'b0;
        end
        hold_out = 1'b0;
      end else if (calm) begin
        @(negedge clk);
        euc_ch.ready <= 1'b1;
      end else begin
        g = pick_gap();
        if (g == 0) begin
          @(negedge clk);
          euc_ch.ready <= 1'b1;
        end else begin
          repeat (g) begin
            @(negedge clk);
            euc_ch.ready <= 1'b0;
          end
        end
      end
    end
  end

  initial begin
    bit hold_done;
    bit pause_done;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    directed = '{
      '{0, 8'h41,                1, 1, 8'h41, i2e_pkg::ERR_NONE},
      '{0, 8'h00,                1, 1, 8'h00, i2e_pkg::ERR_NONE},
      '{0, 8'h7f,                1, 1, 8'h7f, i2e_pkg::ERR_NONE},
      '{0, i2e_pkg::BYTE_SO,     1, 1, 8'h00, i2e_pkg::ERR_INVALID},
      '{0, 8'hff,                1, 1, 8'h00, i2e_pkg::ERR_INVALID},
      '{1, 8'hff,                1, 0, 8'h00, i2e_pkg::ERR_NONE},
      '{0, i2e_pkg::BYTE_ESC,    1, 0, 8'h00, i2e_pkg::ERR_NONE},
      '{0, i2e_pkg::CHAR_DOLLAR, 1, 0, 8'h00, i2e_pkg::ERR_NONE},
      '{0, i2e_pkg::CHAR_B,      1, 0, 8'h00, i2e_pkg::ERR_NONE},
      '{0, i2e_pkg::JIS_LO,      1, 0, 8'h00, i2e_pkg::ERR_NONE},
      '{0, i2e_pkg::JIS_HI,      0, 0, 8'h00, i2e_pkg::ERR_NONE},
      '{0, 8'h20,                1, 1, 8'h00, i2e_pkg::ERR_INVALID},
      '{0, 8'h30,                1, 0, 8'h00, i2e_pkg::ERR_NONE},
      '{1, 8'h00,                1, 1, 8'h00, i2e_pkg::ERR_INCOMPLETE},
      '{0, i2e_pkg::BYTE_ESC,    1, 0, 8'h00, i2e_pkg::ERR_NONE},
      '{0, i2e_pkg::CHAR_PAREN,  1, 0, 8'h00, i2e_pkg::ERR_NONE},
      '{0, i2e_pkg::CHAR_J,      1, 0, 8'h00, i2e_pkg::ERR_NONE},
      '{0, 8'h31,                0, 0, 8'h00, i2e_pkg::ERR_NONE},
      '{0, i2e_pkg::BYTE_ESC,    1, 0, 8'h00, i2e_pkg::ERR_NONE},
      '{0, i2e_pkg::CHAR_DOLLAR, 1, 0, 8'h00, i2e_pkg::ERR_NONE},
      '{0, i2e_pkg::CHAR_AT,     1, 0, 8'h00, i2e_pkg::ERR_NONE},
      '{0, i2e_pkg::JIS_HI,      1, 0, 8'h00, i2e_pkg::ERR_NONE},
      '{0, 8'h7f,                1, 1, 8'h00, i2e_pkg::ERR_INVALID},
      '{0, i2e_pkg::BYTE_ESC,    1, 0, 8'h00, i2e_pkg::ERR_NONE},
      '{0, 8'h58,                0, 0, 8'h00, i2e_pkg::ERR_NONE}
    };
    iso_ch.valid   <= 1'b0;
    iso_ch.op      <= 1'b0;
    iso_ch.in_byte <= 8'h00;
    while (rst) @(posedge clk);

    foreach (directed[i]) offer(directed[i]);

    while (accepted < ITEMS) begin
      fill_burst();
      while (burst_q.size() != 0) begin
        if (!hold_done && accepted >= 200) begin
          hold_out  = 1'b1;
          hold_done = 1'b1;
        end
        if (!pause_done && accepted >= 500) begin
          drain();
          pause_done = 1'b1;
        end
        calm = (accepted >= 650 && accepted < 750);
        offer(burst_q.pop_front());
      end
    end
    calm = 1'b0;

    drain();
    repeat (TAIL_WAIT) @(posedge clk);
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
